### design/stsm_pkg.sv
`timescale 1ns / 1ps
// Package for the square-wave tone synthesizer and mixer.
// Holds shared constants and the control and status types of the serial unit.
// Depends on nothing; used by stsm_serial_md and square_tone_synth_mixer_top.
package stsm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int HZ_W     = 16;
    localparam int MS_W     = 16;
    localparam int RATE_W   = 18;
    localparam int COUNT_W  = 24;
    localparam int MD_OP_W  = 18;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [SAMPLE_W-1:0] TONE_AMP   = 16'h2000;
    localparam logic [SAMPLE_W-1:0] TONE_NEG   = 16'hE000;
    localparam logic [RATE_W-1:0]   MS_PER_S   = 18'd1000;
    localparam logic [RATE_W-1:0]   RATE_RESET = 18'd44100;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 24'hFFFFFF;

    localparam logic REQ_TONE   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic REG_SAMPLE_RATE = 1'b0;

    typedef struct packed {
        logic start;
    } md_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

endpackage

### design/stsm_serial_md.sv
`timescale 1ns / 1ps
// Serial multiply-then-divide unit: shift-add product, then restoring division.
// One bit per cycle in each phase; uses types and constants from stsm_pkg.
module stsm_serial_md #(
    parameter int PHASE_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stsm_pkg::md_ctrl_t            ctrl,
    input  logic [PHASE_BITS-1:0]         mcand,
    input  logic [stsm_pkg::MD_OP_W-1:0]  mplier,
    input  logic [stsm_pkg::MD_OP_W-1:0]  divisor,
    output stsm_pkg::md_stat_t            stat,
    output logic [PHASE_BITS+15:0]        quotient,
    output logic [stsm_pkg::MD_OP_W-1:0]  remainder
);

    localparam int DW = PHASE_BITS + 16;
    localparam int OW = stsm_pkg::MD_OP_W;
    localparam int CW = $clog2(DW + 1);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_MUL  = 3'b010,
        M_DIV  = 3'b100
    } md_state_t;

    md_state_t         state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DW-1:0]     work_reg, work_next;
    logic [DW-1:0]     mc_reg, mc_next;
    logic [OW-1:0]     mp_reg, mp_next;
    logic [OW-1:0]     dvs_reg, dvs_next;
    logic [OW-1:0]     rem_reg, rem_next;
    logic [OW:0]       trial;
    logic [OW:0]       diff;
    logic              qbit;

    assign trial = {rem_reg, work_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        work_next  = work_reg;
        mc_next    = mc_reg;
        mp_next    = mp_reg;
        dvs_next   = dvs_reg;
        rem_next   = rem_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (ctrl.start)
                begin
                    work_next  = '0;
                    mc_next    = DW'(mcand);
                    mp_next    = mplier;
                    dvs_next   = divisor;
                    rem_next   = '0;
                    cnt_next   = CW'(OW - 1);
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                if (mp_reg[0])
                begin
                    work_next = work_reg + mc_reg;
                end
                mc_next = {mc_reg[DW-2:0], 1'b0};
                mp_next = {1'b0, mp_reg[OW-1:1]};
                if (cnt_reg == '0)
                begin
                    cnt_next   = CW'(DW - 1);
                    state_next = M_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            M_DIV:
            begin
                rem_next  = qbit ? diff[OW-1:0] : trial[OW-1:0];
                work_next = {work_reg[DW-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        mc_reg   <= mc_next;
        mp_reg   <= mp_next;
        dvs_reg  <= dvs_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = (state_reg != M_IDLE);
    assign stat.done = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

### design/square_tone_synth_mixer_top.sv
`timescale 1ns / 1ps
// Top level of the square-wave tone synthesizer and mixer.
// Depends on stsm_pkg and instantiates stsm_serial_md.
//
// Items are handled one at a time. A sample item that finds no samples left, a
// silent tone or a zero sample rate finishes without the serial unit. Any other
// sample item uses the shared serial multiply-divide unit once; a tone item uses
// it once with a frequency of 0 and twice otherwise. A finished result waits in
// an output register, so the next item is accepted while the previous result
// has not yet been taken.
module square_tone_synth_mixer_top #(
    parameter int PHASE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stsm_pkg::APB_AW-1:0]         paddr,
    input  logic [stsm_pkg::APB_DW-1:0]         pwdata,
    output logic [stsm_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [stsm_pkg::MS_W-1:0]           tone_ms,
    input  logic [stsm_pkg::HZ_W-1:0]           tone_hz,
    input  logic signed [stsm_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [stsm_pkg::SAMPLE_W-1:0] right_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [stsm_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [stsm_pkg::SAMPLE_W-1:0] right_out,
    output logic                                need_tone,
    output logic                                underrun
);

    localparam int DW = PHASE_BITS + 16;
    localparam int SW = stsm_pkg::SAMPLE_W;
    localparam int OW = stsm_pkg::MD_OP_W;
    localparam int RW = stsm_pkg::RATE_W;
    localparam int NW = stsm_pkg::COUNT_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_PHASE  = 5'b00010,
        S_COUNT  = 5'b00100,
        S_PARITY = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   start_reg, start_next;
    logic [RW-1:0]          rate_reg;
    logic [NW-1:0]          samples_left_reg, samples_left_next;
    logic [stsm_pkg::HZ_W-1:0] cur_hz_reg, cur_hz_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [stsm_pkg::HZ_W-1:0] hz_reg, hz_next;
    logic [stsm_pkg::MS_W-1:0] ms_reg, ms_next;
    logic [SW-1:0]          left_reg, left_next;
    logic [SW-1:0]          right_reg, right_next;
    logic [SW-1:0]          res_left_reg, res_left_next;
    logic [SW-1:0]          res_right_reg, res_right_next;
    logic                   res_need_reg, res_need_next;
    logic                   res_under_reg, res_under_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SW-1:0]          out_left_reg, out_right_reg;
    logic                   out_need_reg, out_under_reg;
    logic                   out_load;

    stsm_pkg::md_ctrl_t     md_ctrl;
    stsm_pkg::md_stat_t     md_stat;
    logic [PHASE_BITS-1:0]  md_mcand;
    logic [OW-1:0]          md_mplier;
    logic [OW-1:0]          md_divisor;
    logic [DW-1:0]          md_quot;
    logic [OW-1:0]          md_rem;
    logic [NW-1:0]          count_sat;
    logic                   odd;
    logic [SW-1:0]          tone_val;
    logic                   cfg_write;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[stsm_pkg::APB_AW-1] == stsm_pkg::REG_SAMPLE_RATE);
    assign prdata    = (paddr[stsm_pkg::APB_AW-1] == stsm_pkg::REG_SAMPLE_RATE)
                       ? stsm_pkg::APB_DW'(rate_reg) : '0;

    // Operand selection for the serial unit; operands are captured on start.
    always_comb
    begin
        case (state_reg)
            S_PHASE:
            begin
                md_mcand   = phase_reg;
                md_mplier  = OW'(cur_hz_reg);
                md_divisor = OW'(hz_reg);
            end
            S_COUNT:
            begin
                md_mcand   = PHASE_BITS'(ms_reg);
                md_mplier  = OW'(rate_reg);
                md_divisor = OW'(stsm_pkg::MS_PER_S);
            end
            default:
            begin
                md_mcand   = phase_reg;
                md_mplier  = OW'(cur_hz_reg);
                md_divisor = OW'(rate_reg);
            end
        endcase
    end

    assign md_ctrl.start = start_reg;

    stsm_serial_md #(
        .PHASE_BITS (PHASE_BITS)
    ) u_md (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (md_ctrl),
        .mcand     (md_mcand),
        .mplier    (md_mplier),
        .divisor   (md_divisor),
        .stat      (md_stat),
        .quotient  (md_quot),
        .remainder (md_rem)
    );

    assign count_sat = (md_quot[DW-1:NW] != '0) ? stsm_pkg::COUNT_MAX : md_quot[NW-1:0];
    assign odd       = ({md_rem, 1'b0} >= {1'b0, OW'(rate_reg)});
    assign tone_val  = odd ? stsm_pkg::TONE_NEG : stsm_pkg::TONE_AMP;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next        = state_reg;
        start_next        = 1'b0;
        samples_left_next = samples_left_reg;
        cur_hz_next       = cur_hz_reg;
        phase_next        = phase_reg;
        hz_next           = hz_reg;
        ms_next           = ms_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        res_left_next     = res_left_reg;
        res_right_next    = res_right_reg;
        res_need_next     = res_need_reg;
        res_under_next    = res_under_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    hz_next    = tone_hz;
                    ms_next    = tone_ms;
                    left_next  = left_in;
                    right_next = right_in;
                    if (req_type == stsm_pkg::REQ_TONE)
                    begin
                        start_next = 1'b1;
                        state_next = (tone_hz != '0) ? S_PHASE : S_COUNT;
                    end
                    else if (samples_left_reg == '0)
                    begin
                        res_left_next  = left_in;
                        res_right_next = right_in;
                        res_need_next  = 1'b1;
                        res_under_next = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (cur_hz_reg == '0)
                    begin
                        res_left_next     = left_in;
                        res_right_next    = right_in;
                        res_need_next     = (samples_left_reg == NW'(1));
                        res_under_next    = 1'b0;
                        samples_left_next = samples_left_reg - 1'b1;
                        state_next        = S_DONE;
                    end
                    else if (rate_reg == '0)
                    begin
                        res_left_next     = left_in + stsm_pkg::TONE_AMP;
                        res_right_next    = right_in + stsm_pkg::TONE_AMP;
                        res_need_next     = (samples_left_reg == NW'(1));
                        res_under_next    = 1'b0;
                        samples_left_next = samples_left_reg - 1'b1;
                        phase_next        = phase_reg + 1'b1;
                        state_next        = S_DONE;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = S_PARITY;
                    end
                end
            end
            S_PHASE:
            begin
                if (md_stat.done)
                begin
                    phase_next = md_quot[PHASE_BITS-1:0];
                    start_next = 1'b1;
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (md_stat.done)
                begin
                    samples_left_next = count_sat;
                    cur_hz_next       = hz_reg;
                    res_left_next     = '0;
                    res_right_next    = '0;
                    res_need_next     = (count_sat == '0);
                    res_under_next    = 1'b0;
                    state_next        = S_DONE;
                end
            end
            S_PARITY:
            begin
                if (md_stat.done)
                begin
                    res_left_next     = left_reg + tone_val;
                    res_right_next    = right_reg + tone_val;
                    res_need_next     = (samples_left_reg == NW'(1));
                    res_under_next    = 1'b0;
                    samples_left_next = samples_left_reg - 1'b1;
                    phase_next        = phase_reg + 1'b1;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            start_reg        <= 1'b0;
            rate_reg         <= stsm_pkg::RATE_RESET;
            samples_left_reg <= '0;
            cur_hz_reg       <= '0;
            phase_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            start_reg        <= start_next;
            samples_left_reg <= samples_left_next;
            cur_hz_reg       <= cur_hz_next;
            phase_reg        <= phase_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_write)
            begin
                rate_reg <= pwdata[RW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hz_reg        <= hz_next;
        ms_reg        <= ms_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        res_need_reg  <= res_need_next;
        res_under_reg <= res_under_next;
        if (out_load)
        begin
            out_left_reg  <= res_left_reg;
            out_right_reg <= res_right_reg;
            out_need_reg  <= res_need_reg;
            out_under_reg <= res_under_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign left_out  = out_left_reg;
    assign right_out = out_right_reg;
    assign need_tone = out_need_reg;
    assign underrun  = out_under_reg;

    a_ready_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !md_stat.busy)
        else $error("Input accepted while the serial unit is still busy.");

    a_done_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        md_stat.done |-> (state_reg == S_PHASE || state_reg == S_COUNT
                          || state_reg == S_PARITY))
        else $error("Serial unit finished outside a working state.");

    a_underrun_needs_tone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!underrun || need_tone))
        else $error("Underrun reported without a request for a new tone.");

endmodule
